FILE: sv/snn_pkg.sv
// Shared types and constants for the spiking network tick engine.
// No dependencies; imported by snn_alu, spiking_network_tick_engine and the testbench.
package snn_pkg;

  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Command codes.
  localparam logic [2:0] OP_LOAD_NEURON  = 3'd0;
  localparam logic [2:0] OP_LOAD_SYNAPSE = 3'd1;
  localparam logic [2:0] OP_FORCE        = 3'd2;
  localparam logic [2:0] OP_TICK         = 3'd3;
  localparam logic [2:0] OP_READ         = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_POT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_N_USE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_S_USE     = 3'd7;

  localparam logic [15:0] RST_RESET_POT = 16'd20000;
  localparam logic [15:0] RST_REST_LOW  = 16'd27500;
  localparam logic [15:0] RST_REST_HIGH = 16'd28500;
  localparam logic [15:0] RST_FLOOR     = 16'd20000;
  localparam logic [15:0] RST_CEILING   = 16'd50000;
  localparam logic [15:0] RST_START_POT = 16'd28000;
  localparam logic [10:0] RST_N_USE     = 11'd1024;
  localparam logic [14:0] RST_S_USE     = 15'd0;

  // Membrane value after reset.
  localparam logic [15:0] MEMBRANE_INIT = 16'd28000;
  localparam logic [10:0] SPIKE_MAX     = 11'd2047;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         neuron_index;
    logic [13:0]        synapse_index;
    logic [15:0]        threshold;
    logic [9:0]         leak;
    logic [5:0]         refractory_steps;
    logic [9:0]         source_neuron;
    logic [9:0]         target_neuron;
    logic [7:0]         delay_steps;
    logic signed [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [10:0] spike_count;
    logic [15:0] potential;
    logic        spiked;
    logic [5:0]  refractory_left;
  } out_item_t;

  // Per-neuron parameters (written by a neuron load only).
  typedef struct packed {
    logic [15:0] thr;
    logic [9:0]  leak;
    logic [5:0]  per;
  } par_t;

  // Per-neuron dynamic flags.
  typedef struct packed {
    logic [5:0] cnt;
    logic       fired;
    logic       forced;
  } nst_t;

  // Synapse entry, delay kept apart since its width is a parameter.
  typedef struct packed {
    logic [9:0]         src;
    logic [9:0]         tgt;
    logic signed [15:0] weight;
  } syn_t;

  // Request to the shared add-and-clamp unit.
  typedef struct packed {
    logic [15:0]        a;
    logic signed [16:0] b;
    logic [15:0]        lo;
    logic [15:0]        hi;
  } alu_req_t;

endpackage

FILE: sv/snn_alu.sv
// Shared add-and-clamp unit: y = min(max(a + b, lo), hi), ceiling wins.
// Depends on snn_pkg (alu_req_t).
module snn_alu
  import snn_pkg::*;
(
  input  alu_req_t    req,
  output logic [15:0] y
);

  logic signed [17:0] sum;
  logic signed [17:0] raised;

  always_comb begin
    sum    = $signed({2'b00, req.a}) + 18'(req.b);
    raised = (sum < $signed({2'b00, req.lo})) ? $signed({2'b00, req.lo}) : sum;
    y      = (raised > $signed({2'b00, req.hi})) ? req.hi : raised[15:0];
  end

endmodule

FILE: sv/spiking_network_tick_engine.sv
// Spiking network tick engine: integer leaky integrate-and-fire network.
// Load neuron, force and read go through ST_OPW, ST_OPX and ST_DONE to the result
// register, load synapse through ST_SLD and ST_DONE, unused opcodes straight to ST_DONE.
// A tick walks every neuron, then the synapses in use, through the one shared adder.
// One item at a time; a full output register holds the result and the input back.
// Reset: synchronous; then a clearing pass over max(NEURONS, SYNAPSES) entries.
module spiking_network_tick_engine
  import snn_pkg::*;
#(
  parameter int NEURONS    = 1024,
  parameter int SYNAPSES   = 16384,
  parameter int DELAY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NI_W  = $clog2(NEURONS);
  localparam int SI_W  = $clog2(SYNAPSES) > 0 ? $clog2(SYNAPSES) : 1;
  localparam int NU_W  = NI_W + 1;
  localparam int SU_W  = SI_W + 1;
  localparam int MAXD  = NEURONS > SYNAPSES ? NEURONS : SYNAPSES;
  localparam int CLR_W = $clog2(MAXD);
  localparam int TMR_W = DELAY_BITS + 1;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_OPW, ST_OPX, ST_SLD, ST_DONE,
    ST_N_RD, ST_N_FIRE, ST_N_UP, ST_N_DN, ST_N_OFF,
    ST_S_RD, ST_S_ENT, ST_S_SW, ST_S_SRC, ST_S_DLV, ST_S_TW, ST_S_ADD, ST_S_FIN
  } state_t;

  // ---------------- configuration registers ----------------
  logic [15:0] reg_rpot_r, reg_rlo_r, reg_rhi_r, reg_floor_r, reg_ceil_r, reg_spot_r;
  logic [10:0] reg_nuse_r;
  logic [14:0] reg_suse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_rpot_r  <= RST_RESET_POT;
      reg_rlo_r   <= RST_REST_LOW;
      reg_rhi_r   <= RST_REST_HIGH;
      reg_floor_r <= RST_FLOOR;
      reg_ceil_r  <= RST_CEILING;
      reg_spot_r  <= RST_START_POT;
      reg_nuse_r  <= RST_N_USE;
      reg_suse_r  <= RST_S_USE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RESET_POT: reg_rpot_r  <= cfg_wdata;
        REG_REST_LOW:  reg_rlo_r   <= cfg_wdata;
        REG_REST_HIGH: reg_rhi_r   <= cfg_wdata;
        REG_FLOOR:     reg_floor_r <= cfg_wdata;
        REG_CEILING:   reg_ceil_r  <= cfg_wdata;
        REG_START_POT: reg_spot_r  <= cfg_wdata;
        REG_N_USE:     reg_nuse_r  <= cfg_wdata[10:0];
        REG_S_USE:     reg_suse_r  <= cfg_wdata[14:0];
        default:       ;
      endcase
    end
  end

  // Clip the in-use counts to the store depths.
  logic [NU_W-1:0] n_use;
  logic [SU_W-1:0] s_use;
  assign n_use = (32'(reg_nuse_r) > NEURONS)  ? NU_W'(NEURONS)  : NU_W'(reg_nuse_r);
  assign s_use = (32'(reg_suse_r) > SYNAPSES) ? SU_W'(SYNAPSES) : SU_W'(reg_suse_r);

  // ---------------- memories ----------------
  logic [15:0]           mem_pot [NEURONS];
  par_t                  mem_par [NEURONS];
  nst_t                  mem_st  [NEURONS];
  syn_t                  mem_syn [SYNAPSES];
  logic [DELAY_BITS-1:0] mem_dly [SYNAPSES];
  logic [TMR_W-1:0]      mem_tmr [SYNAPSES];

  logic [NI_W-1:0] naddr_r, naddr_nxt;
  logic [SI_W-1:0] saddr_r, saddr_nxt;

  logic                  pot_we, par_we, st_we, syn_we, tmr_we;
  logic [NI_W-1:0]       n_wa;
  logic [SI_W-1:0]       s_wa;
  logic [15:0]           pot_wd;
  par_t                  par_wd;
  nst_t                  st_wd;
  logic [TMR_W-1:0]      tmr_wd;

  logic [15:0]           rd_pot_r;
  par_t                  rd_par_r;
  nst_t                  rd_st_r;
  syn_t                  rd_syn_r;
  logic [DELAY_BITS-1:0] rd_dly_r;
  logic [TMR_W-1:0]      rd_tmr_r;

  always_ff @(posedge clk) begin
    if (pot_we) mem_pot[n_wa] <= pot_wd;
    rd_pot_r <= mem_pot[naddr_r];
  end

  always_ff @(posedge clk) begin
    if (par_we) mem_par[n_wa] <= par_wd;
    rd_par_r <= mem_par[naddr_r];
  end

  always_ff @(posedge clk) begin
    if (st_we) mem_st[n_wa] <= st_wd;
    rd_st_r <= mem_st[naddr_r];
  end

  in_item_t item_r, item_nxt;

  always_ff @(posedge clk) begin
    if (syn_we) begin
      mem_syn[s_wa] <= '{src: item_r.source_neuron, tgt: item_r.target_neuron,
                         weight: item_r.weight};
      mem_dly[s_wa] <= DELAY_BITS'(item_r.delay_steps);
    end
    rd_syn_r <= mem_syn[saddr_r];
    rd_dly_r <= mem_dly[saddr_r];
  end

  always_ff @(posedge clk) begin
    if (tmr_we) mem_tmr[s_wa] <= tmr_wd;
    rd_tmr_r <= mem_tmr[saddr_r];
  end

  // ---------------- shared adder ----------------
  alu_req_t    alu_req;
  logic [15:0] alu_y;

  snn_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // ---------------- sequencer ----------------
  state_t          state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic [15:0]     v_r, v_nxt;             // membrane under update
  logic            fired_r, fired_nxt;
  logic [5:0]      ncnt_r, ncnt_nxt;       // refractory count under update
  logic [10:0]     spk_r, spk_nxt;
  logic            tb_r, tb_nxt;           // synapse timer busy
  logic [DELAY_BITS-1:0] tc_r, tc_nxt;     // synapse timer count
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic n_ok, s_ok, fire_thr, src_ok, tgt_ok;
  logic [TMR_W-1:0] tmr_fin;

  assign n_ok     = 32'(item_r.neuron_index) < NEURONS;
  assign s_ok     = 32'(item_r.synapse_index) < SYNAPSES;
  assign fire_thr = (rd_pot_r >= rd_par_r.thr) && (rd_st_r.cnt == 6'd0);
  assign src_ok   = 32'(rd_syn_r.src) < NEURONS;
  assign tgt_ok   = 32'(rd_syn_r.tgt) < NEURONS;
  assign tmr_fin  = {tb_r, (tb_r && tc_r != '0) ? tc_r - 1'b1 : tc_r};

  // Pick the adder operands for the state at hand.
  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_N_UP: begin
        alu_req = '{a: v_r, b: 17'($signed({7'd0, rd_par_r.leak})), lo: 16'd0, hi: 16'hFFFF};
      end
      ST_N_DN: begin
        alu_req = '{a: v_r, b: -17'($signed({7'd0, rd_par_r.leak})), lo: 16'd0,
                    hi: 16'hFFFF};
      end
      ST_S_ADD: begin
        alu_req = '{a: rd_pot_r, b: 17'(rd_syn_r.weight), lo: reg_floor_r, hi: reg_ceil_r};
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    naddr_nxt     = naddr_r;
    saddr_nxt     = saddr_r;
    v_nxt         = v_r;
    fired_nxt     = fired_r;
    ncnt_nxt      = ncnt_r;
    spk_nxt       = spk_r;
    tb_nxt        = tb_r;
    tc_nxt        = tc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pot_we = 1'b0; par_we = 1'b0; st_we = 1'b0; syn_we = 1'b0; tmr_we = 1'b0;
    n_wa   = naddr_r;
    s_wa   = saddr_r;
    pot_wd = '0;
    par_wd = '0;
    st_wd  = '0;
    tmr_wd = '0;

    case (state_r)
      ST_CLR: begin
        // Sweep the potential, state and timer stores with reset values, one entry a cycle.
        n_wa   = NI_W'(clr_r);
        s_wa   = SI_W'(clr_r);
        pot_we = 32'(clr_r) < NEURONS;
        st_we  = 32'(clr_r) < NEURONS;
        tmr_we = 32'(clr_r) < SYNAPSES;
        pot_wd = MEMBRANE_INIT;
        if (32'(clr_r) == MAXD - 1) state_nxt = ST_IDLE;
        else clr_nxt = clr_r + 1'b1;
      end

      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          naddr_nxt = NI_W'(in_data.neuron_index);
          case (in_data.opcode)
            OP_LOAD_NEURON, OP_FORCE, OP_READ: state_nxt = ST_OPW;
            OP_LOAD_SYNAPSE: state_nxt = ST_SLD;
            OP_TICK: begin
              naddr_nxt = '0;
              spk_nxt   = '0;
              state_nxt = ST_N_RD;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_OPW: state_nxt = ST_OPX;

      ST_OPX: begin
        // Neuron words are valid now; act only on an index in range.
        if (n_ok) begin
          case (item_r.opcode)
            OP_LOAD_NEURON: begin
              par_we = 1'b1;
              par_wd = '{thr: item_r.threshold, leak: item_r.leak,
                         per: item_r.refractory_steps};
              pot_we = 1'b1;
              pot_wd = reg_spot_r;
              st_we  = 1'b1;
              st_wd  = '{cnt: 6'd0, fired: rd_st_r.fired, forced: rd_st_r.forced};
            end
            OP_FORCE: begin
              st_we = 1'b1;
              st_wd = '{cnt: rd_st_r.cnt, fired: rd_st_r.fired, forced: 1'b1};
            end
            OP_READ: begin
              res_nxt.potential       = rd_pot_r;
              res_nxt.spiked          = rd_st_r.fired;
              res_nxt.refractory_left = rd_st_r.cnt;
            end
            default: ;
          endcase
        end
        state_nxt = ST_DONE;
      end

      ST_SLD: begin
        s_wa   = SI_W'(item_r.synapse_index);
        syn_we = s_ok;
        tmr_we = s_ok;
        tmr_wd = '0;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_N_RD: state_nxt = ({1'b0, naddr_r} < n_use) ? ST_N_FIRE : ST_N_OFF;

      ST_N_FIRE: begin
        v_nxt     = fire_thr ? reg_rpot_r : rd_pot_r;
        fired_nxt = rd_st_r.forced || fire_thr;
        ncnt_nxt  = fire_thr ? rd_par_r.per : rd_st_r.cnt;
        state_nxt = ST_N_UP;
      end

      ST_N_UP: begin
        if (v_r < reg_rlo_r) v_nxt = alu_y;
        state_nxt = ST_N_DN;
      end

      ST_N_OFF, ST_N_DN: begin
        st_we = 1'b1;
        if (state_r == ST_N_DN) begin
          pot_we = 1'b1;
          pot_wd = (v_r > reg_rhi_r) ? alu_y : v_r;
          st_wd  = '{cnt: (ncnt_r != 6'd0) ? ncnt_r - 6'd1 : ncnt_r, fired: fired_r,
                     forced: 1'b0};
          if (fired_r && spk_r != SPIKE_MAX) spk_nxt = spk_r + 11'd1;
        end else begin
          // Out of use: keep state, drop the fired flag.
          st_wd = '{cnt: rd_st_r.cnt, fired: 1'b0, forced: rd_st_r.forced};
        end
        if (32'(naddr_r) == NEURONS - 1) begin
          res_nxt.spike_count = (state_r == ST_N_DN && fired_r && spk_r != SPIKE_MAX) ?
                                spk_r + 11'd1 : spk_r;
          saddr_nxt = '0;
          state_nxt = (s_use != '0) ? ST_S_RD : ST_DONE;
        end else begin
          naddr_nxt = naddr_r + 1'b1;
          state_nxt = ST_N_RD;
        end
      end

      ST_S_RD: state_nxt = ST_S_ENT;

      ST_S_ENT: begin
        tb_nxt = rd_tmr_r[DELAY_BITS];
        tc_nxt = rd_tmr_r[DELAY_BITS-1:0];
        if (!rd_tmr_r[DELAY_BITS] && src_ok) begin
          naddr_nxt = NI_W'(rd_syn_r.src);
          state_nxt = ST_S_SW;
        end else begin
          state_nxt = ST_S_DLV;
        end
      end

      ST_S_SW: state_nxt = ST_S_SRC;

      ST_S_SRC: begin
        // Arm on a spike of the source in this tick.
        if (rd_st_r.fired) begin
          tb_nxt = 1'b1;
          tc_nxt = rd_dly_r;
        end
        state_nxt = ST_S_DLV;
      end

      ST_S_DLV: begin
        if (tb_r && tc_r == '0) begin
          tb_nxt = 1'b0;
          if (tgt_ok) begin
            naddr_nxt = NI_W'(rd_syn_r.tgt);
            state_nxt = ST_S_TW;
          end else begin
            state_nxt = ST_S_FIN;
          end
        end else begin
          state_nxt = ST_S_FIN;
        end
      end

      ST_S_TW: state_nxt = ST_S_ADD;

      ST_S_ADD: begin
        pot_we    = 1'b1;
        pot_wd    = alu_y;
        state_nxt = ST_S_FIN;
      end

      ST_S_FIN: begin
        tmr_we = 1'b1;
        tmr_wd = tmr_fin;
        if (({1'b0, saddr_r} + 1'b1) < s_use) begin
          saddr_nxt = saddr_r + 1'b1;
          state_nxt = ST_S_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    naddr_r    <= naddr_nxt;
    saddr_r    <= saddr_nxt;
    v_r        <= v_nxt;
    fired_r    <= fired_nxt;
    ncnt_r     <= ncnt_nxt;
    spk_r      <= spk_nxt;
    tb_r       <= tb_nxt;
    tc_r       <= tc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accepted item");

  // Only a tick can report spikes.
  a_spikes_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.spike_count != 11'd0) |-> (item_r.opcode == OP_TICK))
    else $error("spike count on a non-tick item");

  // The clearing pass holds off input after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_ready)
    else $error("input accepted during clearing pass");
`endif

endmodule

FILE: tb/tb_spiking_network_tick_engine.sv
// Self-checking testbench for spiking_network_tick_engine.
// Depends on snn_pkg and the engine RTL; keeps its own network model to predict results.
module tb_spiking_network_tick_engine;
  import snn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEUR = 1024;
  localparam int SYNS = 16384;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spiking_network_tick_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Network shadow: registers, neuron memories, synapse table and delay timers.
  int              reg_shadow [NUM_REGS];
  logic [15:0]     memb [NEUR];
  logic [15:0]     thr [NEUR];
  logic [9:0]      leak [NEUR];
  logic [5:0]      refr_per [NEUR];
  logic [5:0]      refr_cnt [NEUR];
  logic            fired [NEUR];
  logic            forced [NEUR];
  logic [9:0]      syn_src [SYNS];
  logic [9:0]      syn_tgt [SYNS];
  logic [7:0]      syn_dly [SYNS];
  logic signed [15:0] syn_w [SYNS];
  logic            tmr_busy [SYNS];
  int              tmr_cnt [SYNS];

  in_item_t  stim_q [$];
  out_item_t want_q [$];

  int  errors = 0;
  int  items_done = 0;
  int  ticks_done = 0;
  int  spikes_seen = 0;
  bit  quiet = 1'b0;     // no idling, used for bulk preloads
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  // Append an item to the pending stimulus.
  function automatic void stim_add(input in_item_t it);
    stim_q = {stim_q, it};
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int idle_draw();
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // Advance the whole network by one tick; return the spike total.
  function automatic logic [10:0] run_tick();
    int nuse, suse, v, sum;
    logic [10:0] cnt;
    nuse = reg_shadow[REG_N_USE] > NEUR ? NEUR : reg_shadow[REG_N_USE];
    suse = reg_shadow[REG_S_USE] > SYNS ? SYNS : reg_shadow[REG_S_USE];
    cnt = '0;
    for (int i = 0; i < NEUR; i++) begin
      if (i >= nuse) begin
        fired[i] = 1'b0;
      end else begin
        fired[i] = forced[i];
        forced[i] = 1'b0;
        v = memb[i];
        if (v >= thr[i] && refr_cnt[i] == 0) begin
          v = reg_shadow[REG_RESET_POT];
          fired[i] = 1'b1;
          refr_cnt[i] = refr_per[i];
        end
        if (v < reg_shadow[REG_REST_LOW]) begin
          v += leak[i];
          if (v > 65535) v = 65535;
        end
        if (v > reg_shadow[REG_REST_HIGH]) v = (v >= leak[i]) ? v - leak[i] : 0;
        memb[i] = v[15:0];
        if (refr_cnt[i] > 0) refr_cnt[i]--;
        if (fired[i] && cnt < SPIKE_MAX) cnt++;
      end
    end
    for (int s = 0; s < suse; s++) begin
      if (!tmr_busy[s] && fired[syn_src[s]]) begin
        tmr_busy[s] = 1'b1;
        tmr_cnt[s] = int'(syn_dly[s]);
      end
      if (tmr_busy[s] && tmr_cnt[s] == 0) begin
        sum = int'(memb[syn_tgt[s]]) + int'(syn_w[s]);
        if (sum < reg_shadow[REG_FLOOR]) sum = reg_shadow[REG_FLOOR];
        if (sum > reg_shadow[REG_CEILING]) sum = reg_shadow[REG_CEILING];
        memb[syn_tgt[s]] = sum[15:0];
        tmr_busy[s] = 1'b0;
      end
      if (tmr_busy[s] && tmr_cnt[s] > 0) tmr_cnt[s]--;
    end
    return cnt;
  endfunction

  // Apply one command to the shadow and build the result it should produce.
  function automatic out_item_t predict_item(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.opcode)
      OP_LOAD_NEURON: begin
        thr[it.neuron_index] = it.threshold;
        leak[it.neuron_index] = it.leak;
        refr_per[it.neuron_index] = it.refractory_steps;
        memb[it.neuron_index] = 16'(reg_shadow[REG_START_POT]);
        refr_cnt[it.neuron_index] = '0;
      end
      OP_LOAD_SYNAPSE: begin
        syn_src[it.synapse_index] = it.source_neuron;
        syn_tgt[it.synapse_index] = it.target_neuron;
        syn_dly[it.synapse_index] = it.delay_steps;
        syn_w[it.synapse_index] = it.weight;
        tmr_busy[it.synapse_index] = 1'b0;
        tmr_cnt[it.synapse_index] = 0;
      end
      OP_FORCE: forced[it.neuron_index] = 1'b1;
      OP_TICK: begin
        r.spike_count = run_tick();
        ticks_done++;
        spikes_seen += r.spike_count;
      end
      OP_READ: begin
        r.potential = memb[it.neuron_index];
        r.spiked = fired[it.neuron_index];
        r.refractory_left = refr_cnt[it.neuron_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: sample acceptance at the rising edge, change inputs at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      want_q = {want_q, predict_item(in_data)};
      items_done++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap = idle_draw();
        // Keep valid high straight into the next item when no gap is drawn.
        if (in_gap == 0 && stim_q.size() > 0) in_data <= stim_q.pop_front();
        else in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (stim_q.size() > 0) begin
          in_data <= stim_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (want_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        out_item_t w;
        w = want_q.pop_front();
        if (out_data.spike_count !== w.spike_count)
          report($sformatf("spike_count %0d want %0d", out_data.spike_count, w.spike_count));
        if (out_data.potential !== w.potential)
          report($sformatf("potential %0d want %0d", out_data.potential, w.potential));
        if (out_data.spiked !== w.spiked)
          report($sformatf("spiked %0b want %0b", out_data.spiked, w.spiked));
        if (out_data.refractory_left !== w.refractory_left)
          report($sformatf("refractory_left %0d want %0d",
                           out_data.refractory_left, w.refractory_left));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = idle_draw();
        out_ready <= (out_stall == 0);
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= (out_stall == 0);
      end
    end
  end

  // Item builders: unused fields carry random bits.
  function automatic in_item_t rand_bits();
    logic [127:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t mk_op(input logic [2:0] op, input int idx);
    in_item_t it;
    it = rand_bits();
    it.opcode = op;
    it.neuron_index = 10'(idx);
    return it;
  endfunction

  function automatic in_item_t mk_neuron(input int idx, input int th, input int lk,
                                         input int per);
    in_item_t it;
    it = mk_op(OP_LOAD_NEURON, idx);
    it.threshold = 16'(th);
    it.leak = 10'(lk);
    it.refractory_steps = 6'(per);
    return it;
  endfunction

  function automatic in_item_t mk_syn(input int idx, input int src, input int tgt,
                                      input int dly, input int w);
    in_item_t it;
    it = rand_bits();
    it.opcode = OP_LOAD_SYNAPSE;
    it.synapse_index = 14'(idx);
    it.source_neuron = 10'(src);
    it.target_neuron = 10'(tgt);
    it.delay_steps = 8'(dly);
    it.weight = 16'(w);
    return it;
  endfunction

  // Mostly well-formed traffic around the neurons and synapses in use.
  function automatic in_item_t rand_item(input int nuse, input int suse);
    in_item_t it;
    int pick, nspan;
    it = rand_bits();
    nspan = (nuse > NEUR ? NEUR : nuse) - 1;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) it.neuron_index = 10'($urandom_range(0, nspan));
    if (pick < 25) it.opcode = OP_TICK;
    else if (pick < 50) it.opcode = OP_READ;
    else if (pick < 63) it.opcode = OP_FORCE;
    else if (pick < 78) begin
      it.opcode = OP_LOAD_NEURON;
      if ($urandom_range(0, 1)) it.threshold = 16'($urandom_range(20000, 32000));
      if ($urandom_range(0, 1)) it.refractory_steps = 6'($urandom_range(0, 4));
    end else if (pick < 95) begin
      it.opcode = OP_LOAD_SYNAPSE;
      if ($urandom_range(0, 3) != 0) it.synapse_index = 14'($urandom_range(0, suse + 4));
      if ($urandom_range(0, 3) != 0) it.source_neuron = 10'($urandom_range(0, nspan));
      if ($urandom_range(0, 3) != 0) it.target_neuron = 10'($urandom_range(0, nspan));
      if ($urandom_range(0, 3) != 0) it.delay_steps = 8'($urandom_range(0, 3));
    end else begin
      it.opcode = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic drain();
    while (stim_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input int v0, v1, v2, v3, v4, v5, v6, v7);
    int vals [NUM_REGS];
    vals = '{v0, v1, v2, v3, v4, v5, v6, v7};
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= CFG_IDX_W'(i);
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      if (i == REG_N_USE) reg_shadow[i] = vals[i] & 16'h07FF;
      else if (i == REG_S_USE) reg_shadow[i] = vals[i] & 16'h7FFF;
      else reg_shadow[i] = vals[i] & 16'hFFFF;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load every neuron and synapse in use, with no idling.
  task automatic preload(input int nn, input int ns);
    quiet = 1'b1;
    for (int i = 0; i < nn; i++)
      stim_add(mk_neuron(i, $urandom_range(22000, 34000), $urandom_range(0, 1023),
                         $urandom_range(0, 5)));
    for (int s = 0; s < ns; s++)
      stim_add(mk_syn(s, $urandom_range(0, nn - 1), $urandom_range(0, nn - 1),
                      $urandom_range(0, 3), int'($urandom) % 40000));
    drain();
    quiet = 1'b0;
  endtask

  task automatic random_phase(input int count, input int nuse, input int suse);
    for (int k = 0; k < count; k++) stim_add(rand_item(nuse, suse));
    drain();
  endtask

  initial begin
    int nu, su;
    for (int i = 0; i < NEUR; i++) begin
      memb[i] = MEMBRANE_INIT;
      thr[i] = '0; leak[i] = '0; refr_per[i] = '0;
      refr_cnt[i] = '0; fired[i] = 1'b0; forced[i] = 1'b0;
    end
    for (int s = 0; s < SYNS; s++) begin
      syn_src[s] = '0; syn_tgt[s] = '0; syn_dly[s] = '0; syn_w[s] = '0;
      tmr_busy[s] = 1'b0; tmr_cnt[s] = 0;
    end
    reg_shadow = '{RST_RESET_POT, RST_REST_LOW, RST_REST_HIGH, RST_FLOOR, RST_CEILING,
                   RST_START_POT, RST_N_USE, RST_S_USE};

    // Hold reset, then let the clearing pass finish.
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    repeat (SYNS + 64) @(posedge clk);

    // Directed: default levels, eight neurons and six synapses.
    set_regs(20000, 27500, 28500, 20000, 50000, 28000, 8, 6);
    preload(8, 6);
    stim_add(mk_neuron(0, 0, 1023, 63));       // fires on every tick it can
    stim_add(mk_neuron(1, 65535, 0, 0));       // never reaches threshold
    stim_add(mk_neuron(2, 65535, 1023, 0));
    stim_add(mk_syn(0, 1, 2, 0, 32767));       // same-tick delivery, hits ceiling
    stim_add(mk_syn(1, 0, 3, 255, -32768));    // longest delay, heaviest inhibition
    stim_add(mk_syn(2, 1, 4, 1, -32768));      // clamps at floor
    stim_add(mk_syn(16383, 1023, 1023, 7, 5)); // top entry, outside the walk
    stim_add(mk_op(OP_FORCE, 1));
    stim_add(mk_op(OP_FORCE, 1023));           // neuron out of use
    stim_add(mk_op(OP_TICK, 0));
    stim_add(mk_op(OP_READ, 0));
    stim_add(mk_op(OP_READ, 1));
    stim_add(mk_op(OP_READ, 2));
    stim_add(mk_op(OP_READ, 4));
    stim_add(mk_op(OP_TICK, 0));
    stim_add(mk_op(OP_READ, 0));                // still refractory
    stim_add(mk_op(OP_READ, 1023));
    stim_add(mk_op(OP_FORCE, 0));               // forced while refractory
    stim_add(mk_op(OP_TICK, 0));
    stim_add(mk_op(OP_READ, 4));
    stim_add(mk_op(3'd5, 0));
    stim_add(mk_op(3'd6, 1023));
    stim_add(mk_op(3'd7, 512));
    stim_add(mk_neuron(0, 30000, 10, 2));       // reload keeps the fired flag
    stim_add(mk_op(OP_READ, 0));
    drain();

    // Extremes: floor>ceiling, inverted rest band, 1 neuron, no synapses; then full bands.
    set_regs(65535, 65535, 0, 60000, 10000, 0, 1, 0);
    random_phase(25, 1, 0);
    set_regs(0, 0, 65535, 0, 65535, 65535, 8, 6);
    random_phase(15, 8, 6);

    // Random levels and a small network.
    for (int p = 0; p < 1; p++) begin
      nu = $urandom_range(1, 8);
      su = $urandom_range(0, 8);
      set_regs($urandom_range(0, 65535), $urandom_range(20000, 32000),
               $urandom_range(24000, 36000), $urandom_range(0, 30000),
               $urandom_range(30000, 65535), $urandom_range(0, 65535), nu, su);
      preload(nu, su);
      random_phase(10, nu, su);
    end

    $display("covered %0d items, %0d ticks, %0d spikes over four register settings",
             items_done, ticks_done, spikes_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", want_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/snn_pkg.sv
sv/snn_alu.sv
sv/spiking_network_tick_engine.sv
tb/tb_spiking_network_tick_engine.sv
